[hw/rtl/gpth_pkg.sv]
package gpth_pkg;

  typedef enum logic [2:0] {
    OP_WR_DATA = 3'd0,
    OP_WR_CTRL = 3'd1,
    OP_RD_DATA = 3'd2,
    OP_RD_CTRL = 3'd3,
    OP_TICK    = 3'd4,
    OP_LOAD    = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    PAD_NONE  = 2'd0,
    PAD_THREE = 2'd1,
    PAD_SIX   = 2'd2,
    PAD_TWO   = 2'd3
  } pad_type_e;

  // register index on the config port
  localparam logic REG_PAD_TYPE = 1'b0;
  localparam logic REG_LIMIT    = 1'b1;

  localparam int unsigned PaddrWidth = 3;

  localparam pad_type_e   PadTypeReset  = PAD_SIX;
  localparam logic [7:0]  LimitReset    = 8'd25;
  localparam logic [7:0]  HostDataReset = 8'hFF;
  localparam logic [7:0]  PadDataReset  = 8'hFF;
  localparam logic [11:0] ButtonsReset  = 12'hFFF;
  localparam int unsigned ThBit         = 6;

  typedef struct packed {
    pad_type_e  pad_type;
    logic [7:0] scanline_limit;
    logic       clear_port;
  } cfg_t;

  // buttons: 0 up, 1 down, 2 left, 3 right, 4 b, 5 c, 6 a, 7 start,
  // 8 z, 9 y, 10 x, 11 mode
  function automatic logic [7:0] three_high(input logic [11:0] btn);
    three_high = {2'b01, btn[5:0]};
  endfunction

  function automatic logic [7:0] three_low(input logic [11:0] btn);
    three_low = {2'b00, btn[7:6], 2'b00, btn[1:0]};
  endfunction

endpackage

[hw/rtl/gpth_cfg_regs.sv]
module gpth_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gpth_pkg::PaddrWidth-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output gpth_pkg::cfg_t                      cfg_o
);

  gpth_pkg::pad_type_e pad_type_q, pad_type_d;
  logic [7:0]          limit_q, limit_d;
  logic                wr_en;
  logic                reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    pad_type_d = pad_type_q;
    limit_d    = limit_q;
    if (wr_en) begin
      case (reg_idx)
        gpth_pkg::REG_PAD_TYPE: pad_type_d = gpth_pkg::pad_type_e'(pwdata[1:0]);
        gpth_pkg::REG_LIMIT:    limit_d    = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_type_q <= gpth_pkg::PadTypeReset;
      limit_q    <= gpth_pkg::LimitReset;
    end else begin
      pad_type_q <= pad_type_d;
      limit_q    <= limit_d;
    end
  end

  always_comb begin
    case (reg_idx)
      gpth_pkg::REG_PAD_TYPE: prdata = {30'd0, pad_type_q};
      gpth_pkg::REG_LIMIT:    prdata = {24'd0, limit_q};
      default:                prdata = 32'd0;
    endcase
  end

  assign cfg_o.pad_type       = pad_type_q;
  assign cfg_o.scanline_limit = limit_q;
  // writing the pad type restarts the port
  assign cfg_o.clear_port     = wr_en && (reg_idx == gpth_pkg::REG_PAD_TYPE);

endmodule

[hw/rtl/gpth_port_core.sv]
module gpth_port_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gpth_pkg::cfg_t      cfg_i,
  input  logic                fire_i,
  input  gpth_pkg::opcode_e   opcode_i,
  input  logic [7:0]          write_value_i,
  input  logic [11:0]         button_bits_i,
  output logic [7:0]          read_value_o
);

  logic [7:0]  tri_q, tri_d;
  logic [7:0]  host_q, host_d;
  logic [7:0]  pad_q, pad_d;
  logic        sel_q, sel_d;
  logic [1:0]  phase_q, phase_d;   // phase count divided by two
  logic [7:0]  line_q, line_d;
  logic [11:0] btn_q, btn_d;

  logic        update;
  logic [2:0]  six_idx;
  logic [8:0]  line_inc;

  always_comb begin
    tri_d   = tri_q;
    host_d  = host_q;
    btn_d   = btn_q;
    pad_d   = pad_q;
    sel_d   = sel_q;
    phase_d = phase_q;
    line_d  = line_q;
    update  = 1'b0;
    six_idx = 3'd0;
    line_inc = {1'b0, line_q} + 9'd1;

    if (fire_i) begin
      case (opcode_i)
        gpth_pkg::OP_WR_DATA: begin
          host_d = write_value_i;
          update = 1'b1;
        end
        gpth_pkg::OP_WR_CTRL: begin
          tri_d  = write_value_i;
          update = 1'b1;
        end
        gpth_pkg::OP_LOAD: begin
          btn_d  = button_bits_i;
          update = 1'b1;
        end
        gpth_pkg::OP_TICK: begin
          if (cfg_i.pad_type == gpth_pkg::PAD_SIX) begin
            if (line_inc > {1'b0, cfg_i.scanline_limit}) begin
              phase_d = 2'd0;
              line_d  = 8'd0;
            end else begin
              line_d = line_inc[7:0];
            end
          end
        end
        default: ;
      endcase
    end

    if (update) begin
      sel_d = !tri_d[gpth_pkg::ThBit] || host_d[gpth_pkg::ThBit];
      case (cfg_i.pad_type)
        gpth_pkg::PAD_THREE: begin
          pad_d = sel_d ? gpth_pkg::three_high(btn_d) : gpth_pkg::three_low(btn_d);
        end
        gpth_pkg::PAD_SIX: begin
          // th rising edge steps the extended phase
          if (!sel_q && sel_d) begin
            phase_d = phase_q + 2'd1;
            line_d  = 8'd0;
          end
          six_idx = {phase_d, !sel_d};
          case (six_idx)
            3'd0, 3'd2, 3'd4: pad_d = gpth_pkg::three_high(btn_d);
            3'd1, 3'd3:       pad_d = gpth_pkg::three_low(btn_d);
            3'd5:             pad_d = {2'b00, btn_d[7:6], 4'b0000};
            3'd6:             pad_d = {2'b01, btn_d[5:4], btn_d[11:8]};
            default:          pad_d = {2'b00, btn_d[7:6], 4'b1111};
          endcase
        end
        gpth_pkg::PAD_TWO: pad_d = {2'b11, btn_d[5:0]};
        default: ;
      endcase
    end

    if (cfg_i.clear_port) begin
      tri_d   = 8'd0;
      host_d  = gpth_pkg::HostDataReset;
      pad_d   = gpth_pkg::PadDataReset;
      sel_d   = 1'b0;
      phase_d = 2'd0;
      line_d  = 8'd0;
      btn_d   = gpth_pkg::ButtonsReset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_q   <= 8'd0;
      host_q  <= gpth_pkg::HostDataReset;
      pad_q   <= gpth_pkg::PadDataReset;
      sel_q   <= 1'b0;
      phase_q <= 2'd0;
      line_q  <= 8'd0;
      btn_q   <= gpth_pkg::ButtonsReset;
    end else begin
      tri_q   <= tri_d;
      host_q  <= host_d;
      pad_q   <= pad_d;
      sel_q   <= sel_d;
      phase_q <= phase_d;
      line_q  <= line_d;
      btn_q   <= btn_d;
    end
  end

  always_comb begin
    read_value_o = 8'd0;
    if (fire_i) begin
      case (opcode_i)
        gpth_pkg::OP_RD_DATA:
          read_value_o = (pad_q & ~tri_q & 8'h7F) | (host_q & (tri_q | 8'h80));
        gpth_pkg::OP_RD_CTRL: read_value_o = tri_q;
        default: read_value_o = 8'd0;
      endcase
    end
  end

  // phase only moves on a six-button pad or on a port restart
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.pad_type != gpth_pkg::PAD_SIX && !cfg_i.clear_port) |=> $stable(phase_q))
    else $error("phase count moved on a pad without extended phases");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.clear_port |=> (host_q == gpth_pkg::HostDataReset && phase_q == 2'd0
                          && line_q == 8'd0 && !sel_q))
    else $error("port restart did not clear the port state");

  // select level follows the written registers after each data or control write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (opcode_i == gpth_pkg::OP_WR_DATA || opcode_i == gpth_pkg::OP_WR_CTRL)
     && !cfg_i.clear_port)
    |=> sel_q == (!tri_q[gpth_pkg::ThBit] || host_q[gpth_pkg::ThBit]))
    else $error("select line does not match the written registers");

endmodule

[hw/rtl/gamepad_port_th_protocol.sv]
// Controller port model with select-line (th) multiplexing for 2-, 3- and
// 6-button pads.
// Input channel: opcode_i, write_value_i and button_bits_i travel as one beat
// under in_valid_i / in_stall_o. Every beat gives exactly one result beat on
// read_value_o under out_valid_o / out_stall_i: the read byte for read data
// and read control, zero for every other opcode.
// A beat passes through two registers: the input register, then the result
// register. Throughput is one beat per cycle when the output is not stalled,
// set by the single update of the port state between the two registers.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; in_stall_o rises only when both are
// full and the output is stalled.
// Configuration via the apb-style port: pad type at byte address 0, scanline
// limit at address 4. The user writes them only while the block is idle; the
// block does not enforce it. Writing the pad type restarts the port state.
// Reset: pad type six-button, limit 25, tristate control 0, host and pad
// data 0xff, buttons all released, counters cleared, both channels empty.
module gamepad_port_th_protocol (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gpth_pkg::PaddrWidth-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        opcode_i,
  input  logic [7:0]                        write_value_i,
  input  logic [11:0]                       button_bits_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        read_value_o
);

  gpth_pkg::cfg_t     cfg;
  logic               in_valid_q, in_valid_d;
  gpth_pkg::opcode_e  op_q;
  logic [7:0]         val_q;
  logic [11:0]        btn_q;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         result_q;
  logic [7:0]         result;
  logic               out_free;
  logic               fire;
  logic               accept;

  gpth_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= gpth_pkg::opcode_e'(opcode_i);
      val_q <= write_value_i;
      btn_q <= button_bits_i;
    end
    if (fire) begin
      result_q <= result;
    end
  end

  gpth_port_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .fire_i        (fire),
    .opcode_i      (op_q),
    .write_value_i (val_q),
    .button_bits_i (btn_q),
    .read_value_o  (result)
  );

  assign out_valid_o  = out_valid_q;
  assign read_value_o = result_q;

  // a beat leaving the input register always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed beat was lost");

  // input side only pushes back when both registers hold a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with free room");

  // a stalled result beat stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(result_q)))
    else $error("stalled result beat changed");

endmodule
